/* design/qpsg_pkg.sv */
// Package: constants, correction tables and shared types for the phase schedule generator.
`default_nettype none

package qpsg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int CORR_LEN   = 71;
  localparam int ECHO_W     = 10;
  localparam int OUT_W      = PHASE_BITS + 1;
  localparam int CORR_IDX_W = $clog2(CORR_LEN);

  localparam longint unsigned XCORR_DEN = 200000;
  localparam longint unsigned RCORR_DEN = 100000;

  localparam logic [PHASE_BITS-1:0] STEP_D = PHASE_BITS'(
    ((longint'(161) <<< (PHASE_BITS + 1)) + 843) / (2 * 843));
  localparam logic [PHASE_BITS-1:0] STEP_INIT = PHASE_BITS'(
    ((longint'(1165) <<< (PHASE_BITS + 1)) + 3372) / (2 * 3372));
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(longint'(1) <<< (PHASE_BITS - 1));

  typedef logic [PHASE_BITS-1:0] phase_tbl_t [CORR_LEN];

  localparam int CORR_K [CORR_LEN] = '{
    -2376, -2515, -6971, -2034, 4780, -4694, -10170, -3567, 2410, 4447,
    8831, 4056, 3200, -1339, -1842, -5396, -7111, -5064, -5032, -3439,
    -3182, -461, 1491, 974, 3490, 3166, 4383, 1516, 1695, 960,
    -437, -1279, -1294, -418, -780, -1405, 213, -675, -285, -2021,
    -396, -1423, -1819, -1700, -920, -318, -782, 477, 1699, 1377,
    1885, 1458, 2836, 535, 849, -242, 145, -1608, -1692, -1521,
    -1479, -2158, -1574, -1012, -503, -1184, 42, 270, 595, 0, 0
  };

  function automatic logic [PHASE_BITS-1:0] x_turns(int k);
    longint unsigned mag;
    longint unsigned q;
    mag = (k < 0) ? longint'(-k) : longint'(k);
    q = ((mag << (PHASE_BITS + 1)) + XCORR_DEN) / (2 * XCORR_DEN);
    return (k < 0) ? PHASE_BITS'(-q) : PHASE_BITS'(q);
  endfunction

  function automatic logic [PHASE_BITS-1:0] r_turns(int k);
    longint unsigned mag;
    longint unsigned q;
    mag = (k < 0) ? longint'(-k) : longint'(k);
    q = ((mag << (PHASE_BITS + 1)) + RCORR_DEN) / (2 * RCORR_DEN);
    return (k < 0) ? PHASE_BITS'(-q) : PHASE_BITS'(q);
  endfunction

  localparam logic [PHASE_BITS-1:0] BIAS = r_turns(CORR_K[0]);

  // Last entry carries the bias alone.
  function automatic phase_tbl_t build_x_tbl();
    phase_tbl_t t;
    for (int i = 0; i < CORR_LEN - 1; i++) begin
      t[i] = x_turns(CORR_K[i] + CORR_K[i+1]) - BIAS;
    end
    t[CORR_LEN-1] = PHASE_BITS'(0) - BIAS;
    return t;
  endfunction

  function automatic phase_tbl_t build_r_tbl();
    phase_tbl_t t;
    for (int i = 0; i < CORR_LEN - 1; i++) begin
      t[i] = r_turns(CORR_K[i+1]) - BIAS;
    end
    t[CORR_LEN-1] = PHASE_BITS'(0) - BIAS;
    return t;
  endfunction

  localparam phase_tbl_t X_TBL = build_x_tbl();
  localparam phase_tbl_t R_TBL = build_r_tbl();

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] step;
    logic [ECHO_W-1:0]     echo;
    logic                  last;
    logic [CORR_IDX_W-1:0] corr_idx;
  } echo_ctx_t;

endpackage

`default_nettype wire

/* design/qpsg_out_stage.sv */
// Output stage: applies corrections, centers phases and holds the result item.
`default_nettype none

module qpsg_out_stage
  import qpsg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ctx_valid,
  input  wire echo_ctx_t        ctx,
  output logic                  ctx_ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [OUT_W-1:0] out_refocus_phase,
  output logic signed [OUT_W-1:0] out_excite_phase,
  output logic [ECHO_W-1:0]     out_echo_index,
  output logic                  out_last
);

  logic                    valid_r;
  logic [OUT_W-1:0]        refocus_r, refocus_nxt;
  logic [OUT_W-1:0]        excite_r, excite_nxt;
  logic [ECHO_W-1:0]       echo_r;
  logic                    last_r;
  logic [PHASE_BITS-1:0]   r_val;
  logic [PHASE_BITS-1:0]   x_val;

  assign ctx_ready = !valid_r || !out_stall;

  always_comb begin
    r_val = ctx.phase + R_TBL[ctx.corr_idx];
    x_val = ctx.phase - ctx.step + X_TBL[ctx.corr_idx];
    refocus_nxt = {(r_val > PHASE_HALF), r_val};
    excite_nxt  = {(x_val > PHASE_HALF), x_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctx_ready) begin
      valid_r <= ctx_valid;
    end
    if (ctx_ready && ctx_valid) begin
      refocus_r <= refocus_nxt;
      excite_r  <= excite_nxt;
      echo_r    <= ctx.echo;
      last_r    <= ctx.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_refocus_phase = refocus_r;
  assign out_excite_phase  = excite_r;
  assign out_echo_index    = echo_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

/* design/quadratic_phase_schedule_generator.sv */
// Top level: quadratic phase schedule generator with echo accumulators and output stage.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   in_      | in_valid / in_stall    | in_restart
//   out_     | out_valid / out_stall  | out_refocus_phase, out_excite_phase,
//            |                        | out_echo_index, out_last
//   cfg_     | cfg_we                 | cfg_wdata (train_length)
//
// One echo per clock while the output does not stall; an accepted item passes through
// the context register, then the result register, before it is shown on the output.
// The phase and step accumulators each close through one register, which sets the rate.
// Reset loads train_length 64, step to D/2 + 1/4, phase 0, echo 0; no clearing pass.
// A stall on the output holds the result register; the context register still
// takes an item while it is empty or while the result register is free or being read.
`default_nettype none

module quadratic_phase_schedule_generator
  import qpsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [ECHO_W-1:0]  cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [OUT_W-1:0] out_refocus_phase,
  output logic signed [OUT_W-1:0] out_excite_phase,
  output logic [ECHO_W-1:0]       out_echo_index,
  output logic                    out_last
);

  logic [ECHO_W-1:0]     train_len_r;
  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [ECHO_W-1:0]     echo_r, echo_nxt;
  logic                  s1_valid_r;
  echo_ctx_t             s1_ctx_r, s1_ctx_nxt;

  logic                  st_ready;
  logic                  accept;
  logic [PHASE_BITS-1:0] base_step;
  logic [PHASE_BITS-1:0] base_phase;
  logic [ECHO_W-1:0]     base_echo;
  logic [ECHO_W-1:0]     len_eff;
  logic [PHASE_BITS-1:0] sum_phase;
  logic                  is_last;

  assign in_stall = s1_valid_r && !st_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    base_step  = in_restart ? STEP_INIT : step_r;
    base_phase = in_restart ? '0 : phase_r;
    base_echo  = in_restart ? '0 : echo_r;
    len_eff    = (train_len_r == '0) ? ECHO_W'(1) : train_len_r;
    sum_phase  = base_phase + {base_step[PHASE_BITS-2:0], 1'b0};
    is_last    = ({1'b0, base_echo} + (ECHO_W+1)'(1)) >= {1'b0, len_eff};

    s1_ctx_nxt.phase    = sum_phase;
    s1_ctx_nxt.step     = base_step;
    s1_ctx_nxt.echo     = base_echo;
    s1_ctx_nxt.last     = is_last;
    s1_ctx_nxt.corr_idx = (!is_last && base_echo < ECHO_W'(CORR_LEN - 1))
                          ? base_echo[CORR_IDX_W-1:0] : CORR_IDX_W'(CORR_LEN - 1);

    if (is_last) begin
      step_nxt  = STEP_INIT;
      phase_nxt = '0;
      echo_nxt  = '0;
    end else begin
      step_nxt  = base_step + STEP_D;
      phase_nxt = sum_phase;
      echo_nxt  = base_echo + ECHO_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_len_r <= ECHO_W'(64);
      step_r      <= STEP_INIT;
      phase_r     <= '0;
      echo_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        train_len_r <= cfg_wdata;
      end
      if (accept) begin
        step_r     <= step_nxt;
        phase_r    <= phase_nxt;
        echo_r     <= echo_nxt;
        s1_valid_r <= 1'b1;
      end else if (st_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      s1_ctx_r <= s1_ctx_nxt;
    end
  end

  qpsg_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctx_valid         (s1_valid_r),
    .ctx               (s1_ctx_r),
    .ctx_ready         (st_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_refocus_phase (out_refocus_phase),
    .out_excite_phase  (out_excite_phase),
    .out_echo_index    (out_echo_index),
    .out_last          (out_last)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r) else $error("input stalled with empty context stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r) else $error("accepted item missing from context stage");

  a_restart_echo0: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart) |=> (s1_ctx_r.echo == '0))
    else $error("restart did not start at echo 0");

  a_echo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    echo_r != '1) else $error("echo counter out of range");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_last) |=> (echo_r == '0 && phase_r == '0))
    else $error("accumulators not reinitialized after last echo");

endmodule

`default_nettype wire
